[rtl/assert_macros.svh]
// Assertion macros used by the checker file frp_chk.sv.
// Depends on nothing; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frp: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frp: next-cycle check failed");

`endif

[rtl/frp_pkg.sv]
// Shared types, codes and defaults of the flash record ring pointer.
// Used by every module of the block; depends on nothing.
package frp_pkg;

    localparam int DEF_SECTOR_COUNT     = 2;
    localparam int DEF_SLOTS_PER_SECTOR = 20;

    localparam logic [31:0] RST_REGION_BASE = 32'd0;
    localparam logic [20:0] RST_SECTOR_BYTES = 21'd4096;
    localparam logic [12:0] RST_RECORD_BYTES = 13'd200;
    localparam logic [31:0] RST_PERIOD_MS = 32'd1000;

    localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [1:0] CFG_SECTOR_BYTES = 2'd1;
    localparam logic [1:0] CFG_RECORD_BYTES = 2'd2;
    localparam logic [1:0] CFG_PERIOD_MS    = 2'd3;

    typedef enum logic [1:0] {
        CMD_SCAN = 2'd0,
        CMD_DONE = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_RESTORE = 2'd0,
        ACT_FRESH   = 2'd1,
        ACT_ERASE   = 2'd2,
        ACT_WRITE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [31:0] region_base_addr;
        logic [20:0] sector_bytes;
        logic [12:0] record_bytes;
        logic [31:0] snapshot_period_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  sector_index;
        logic [7:0]  slot_index;
        logic        record_valid;
        logic [31:0] record_seq;
        logic [31:0] now_ms;
    } t_item;

    // One queued result; with two_words set an erase of the same sector goes out first.
    typedef struct packed {
        logic        two_words;
        t_action     action;
        logic [31:0] addr;
        logic [31:0] seq;
    } t_res;

endpackage

[rtl/frp_core.sv]
// Ring pointer state, scan tracking and flash address computation.
// Depends on frp_pkg.
module frp_core #(
    parameter int SECTOR_COUNT     = frp_pkg::DEF_SECTOR_COUNT,
    parameter int SLOTS_PER_SECTOR = frp_pkg::DEF_SLOTS_PER_SECTOR
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  frp_pkg::t_item i_item,
    input  frp_pkg::t_cfg  i_cfg,
    output logic           o_push,
    output frp_pkg::t_res  o_res
);
    import frp_pkg::*;

    localparam int SCW = $clog2(SECTOR_COUNT);
    localparam int SLW = $clog2(SLOTS_PER_SECTOR + 1);

    logic [31:0]    r_next_seq, n_next_seq;
    logic [SCW-1:0] r_sector, n_sector;
    logic [SLW-1:0] r_slot, n_slot;
    logic           r_known, n_known;
    logic [31:0]    r_last_ms, n_last_ms;
    logic           r_found, n_found;
    logic [31:0]    r_best_seq, n_best_seq;
    logic [SCW-1:0] r_best_sector, n_best_sector;
    logic [SLW-1:0] r_best_slot, n_best_slot;

    logic           in_ring;
    logic           elapsed;
    logic           rotate;
    logic [SCW-1:0] eff_sector;
    logic [SLW-1:0] eff_slot;
    logic [31:0]    sector_off;
    logic [31:0]    slot_off;
    logic [31:0]    addr;

    assign in_ring = i_item.record_valid
                   && ({1'b0, i_item.sector_index} < 5'(SECTOR_COUNT))
                   && ({1'b0, i_item.slot_index} < 9'(SLOTS_PER_SECTOR));
    assign elapsed = (i_item.now_ms - r_last_ms) >= i_cfg.snapshot_period_ms;
    assign rotate  = r_slot >= SLW'(SLOTS_PER_SECTOR);

    // Pick the sector and slot whose address this word reports.
    always_comb begin
        eff_sector = '0;
        eff_slot   = '0;
        if (i_item.cmd == CMD_DONE) begin
            if (r_found) begin
                eff_sector = r_best_sector;
                eff_slot   = r_best_slot;
            end
        end else if (rotate) begin
            eff_sector = (r_sector == SCW'(SECTOR_COUNT - 1)) ? '0 : r_sector + SCW'(1);
        end else begin
            eff_sector = r_sector;
            eff_slot   = r_slot;
        end
    end

    assign sector_off = 32'(eff_sector) * 32'(i_cfg.sector_bytes);
    assign slot_off   = 32'(eff_slot) * 32'(i_cfg.record_bytes);
    assign addr       = i_cfg.region_base_addr + sector_off + slot_off;

    always_comb begin
        n_next_seq    = r_next_seq;
        n_sector      = r_sector;
        n_slot        = r_slot;
        n_known       = r_known;
        n_last_ms     = r_last_ms;
        n_found       = r_found;
        n_best_seq    = r_best_seq;
        n_best_sector = r_best_sector;
        n_best_slot   = r_best_slot;
        o_push        = 1'b0;
        o_res.two_words = 1'b0;
        o_res.action    = ACT_FRESH;
        o_res.addr      = addr;
        o_res.seq       = '0;
        if (i_go) begin
            unique case (i_item.cmd)
                CMD_SCAN: begin
                    // First of equal sequence numbers wins.
                    if (in_ring && (!r_found || i_item.record_seq > r_best_seq)) begin
                        n_found       = 1'b1;
                        n_best_seq    = i_item.record_seq;
                        n_best_sector = i_item.sector_index[SCW-1:0];
                        n_best_slot   = SLW'(i_item.slot_index);
                    end
                end
                CMD_DONE: begin
                    o_push = 1'b1;
                    if (r_found) begin
                        o_res.action = ACT_RESTORE;
                        o_res.seq    = r_best_seq;
                        n_next_seq   = r_best_seq + 32'd1;
                        if (r_best_slot == SLW'(SLOTS_PER_SECTOR - 1)) begin
                            n_sector = (r_best_sector == SCW'(SECTOR_COUNT - 1)) ? '0
                                     : r_best_sector + SCW'(1);
                            n_slot   = '0;
                        end else begin
                            n_sector = r_best_sector;
                            n_slot   = r_best_slot + SLW'(1);
                        end
                    end else begin
                        o_res.action = ACT_FRESH;
                        n_next_seq   = '0;
                        n_sector     = '0;
                        n_slot       = '0;
                    end
                    n_known       = 1'b1;
                    n_last_ms     = i_item.now_ms;
                    n_found       = 1'b0;
                    n_best_seq    = '0;
                    n_best_sector = '0;
                    n_best_slot   = '0;
                end
                CMD_TICK: begin
                    if (elapsed) begin
                        if (r_known) begin
                            o_push          = 1'b1;
                            o_res.two_words = rotate;
                            o_res.action    = ACT_WRITE;
                            o_res.seq       = r_next_seq;
                            n_next_seq      = r_next_seq + 32'd1;
                            n_sector        = eff_sector;
                            n_slot          = eff_slot + SLW'(1);
                        end
                        n_last_ms = i_item.now_ms;
                    end
                end
                CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq    <= '0;
            r_sector      <= '0;
            r_slot        <= '0;
            r_known       <= 1'b0;
            r_last_ms     <= '0;
            r_found       <= 1'b0;
            r_best_seq    <= '0;
            r_best_sector <= '0;
            r_best_slot   <= '0;
        end else begin
            r_next_seq    <= n_next_seq;
            r_sector      <= n_sector;
            r_slot        <= n_slot;
            r_known       <= n_known;
            r_last_ms     <= n_last_ms;
            r_found       <= n_found;
            r_best_seq    <= n_best_seq;
            r_best_sector <= n_best_sector;
            r_best_slot   <= n_best_slot;
        end
    end

endmodule

[rtl/frp_outq.sv]
// Two-entry result queue; an entry marked two_words leaves as an erase word then a write.
// Depends on frp_pkg.
module frp_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  frp_pkg::t_res i_res,
    output logic          o_can_push,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_action,
    output logic [31:0]   o_flash_addr,
    output logic [31:0]   o_seq_out,
    output logic          o_last
);
    import frp_pkg::*;

    localparam logic [1:0] QDEPTH = 2'd2;

    t_res       r_q [2];
    logic       r_wp, r_rp, r_sub;
    logic [1:0] r_cnt;

    t_res head;
    logic erase_phase;
    logic pop_word;
    logic pop_entry;

    assign head        = r_q[r_rp];
    assign erase_phase = head.two_words && !r_sub;
    assign o_valid     = r_cnt != 2'd0;
    assign pop_word    = o_valid && !i_stall;
    assign pop_entry   = pop_word && !erase_phase;
    assign o_can_push  = (r_cnt != QDEPTH) || pop_entry;

    assign o_action     = erase_phase ? ACT_ERASE : head.action;
    assign o_flash_addr = head.addr;
    assign o_seq_out    = erase_phase ? 32'd0 : head.seq;
    assign o_last       = !erase_phase;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_sub <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop_entry) begin
                r_rp  <= !r_rp;
                r_sub <= 1'b0;
            end else if (pop_word) begin
                r_sub <= 1'b1;   // erase word sent, hold entry for its write
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop_entry);
        end
    end

endmodule

[rtl/flash_record_ring_pointer_top.sv]
// Top level of the flash record ring pointer: config registers, input register,
// core and result queue. Depends on frp_pkg, frp_core and frp_outq.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_cmd .. i_now_ms
//   result    out        o_valid / i_stall    o_action .. o_last
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One input word per cycle unless stalled; results pass the input register and queue.
// A tick that rotates to a new sector puts two words on the result side, so the
// result port sets the rate when rotations follow closely.
// Reset is synchronous; control state clears, config returns to its defaults.
// A stalled result side fills the two-entry queue, then stalls done and tick words.
module flash_record_ring_pointer_top #(
    parameter int SECTOR_COUNT     = frp_pkg::DEF_SECTOR_COUNT,
    parameter int SLOTS_PER_SECTOR = frp_pkg::DEF_SLOTS_PER_SECTOR
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_sector_index,
    input  logic [7:0]  i_slot_index,
    input  logic        i_record_valid,
    input  logic [31:0] i_record_seq,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_action,
    output logic [31:0] o_flash_addr,
    output logic [31:0] o_seq_out,
    output logic        o_last
);
    import frp_pkg::*;

    t_cfg  r_cfg;
    t_item r_item;
    logic  r_item_valid;
    logic  can_push;
    logic  no_result;
    logic  proc_go;
    logic  push;
    t_res  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_base_addr   <= RST_REGION_BASE;
            r_cfg.sector_bytes       <= RST_SECTOR_BYTES;
            r_cfg.record_bytes       <= RST_RECORD_BYTES;
            r_cfg.snapshot_period_ms <= RST_PERIOD_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REGION_BASE:  r_cfg.region_base_addr   <= i_cfg_data;
                CFG_SECTOR_BYTES: r_cfg.sector_bytes       <= i_cfg_data[20:0];
                CFG_RECORD_BYTES: r_cfg.record_bytes       <= i_cfg_data[12:0];
                CFG_PERIOD_MS:    r_cfg.snapshot_period_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Scan words and unused codes never produce a result, so they need no queue room.
    assign no_result = (r_item.cmd == CMD_SCAN) || (r_item.cmd == CMD_NONE);
    assign proc_go   = r_item_valid && (no_result || can_push);
    assign o_stall   = r_item_valid && !proc_go;

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.cmd          <= t_cmd'(i_cmd);
            r_item.sector_index <= i_sector_index;
            r_item.slot_index   <= i_slot_index;
            r_item.record_valid <= i_record_valid;
            r_item.record_seq   <= i_record_seq;
            r_item.now_ms       <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_item_valid <= 1'b1;
        end else if (proc_go) begin
            r_item_valid <= 1'b0;
        end
    end

    frp_core #(
        .SECTOR_COUNT     (SECTOR_COUNT),
        .SLOTS_PER_SECTOR (SLOTS_PER_SECTOR)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (proc_go),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_res   (res)
    );

    frp_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_res        (res),
        .o_can_push   (can_push),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_action     (o_action),
        .o_flash_addr (o_flash_addr),
        .o_seq_out    (o_seq_out),
        .o_last       (o_last)
    );

endmodule

[rtl/frp_chk.sv]
// Port-level checker for the flash record ring pointer, bound to the top level.
// Depends on frp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_index,
    input logic [31:0] i_cfg_data,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_cmd,
    input logic [3:0]  i_sector_index,
    input logic [7:0]  i_slot_index,
    input logic        i_record_valid,
    input logic [31:0] i_record_seq,
    input logic [31:0] i_now_ms,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_action,
    input logic [31:0] o_flash_addr,
    input logic [31:0] o_seq_out,
    input logic        o_last
);
    import frp_pkg::*;

    // hold a stalled result word
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_flash_addr))
    // erase word carries no sequence and never closes a word's results
    `ASSERT_IMPLIES(a_erase_form, i_clk, i_rst_n, o_valid && (o_action == ACT_ERASE), !o_last && (o_seq_out == 32'd0))
    // erase is followed at once by the write to the same sector
    `ASSERT_NEXT(a_erase_then_write, i_clk, i_rst_n, o_valid && !i_stall && (o_action == ACT_ERASE), o_valid && (o_action == ACT_WRITE))

endmodule

bind flash_record_ring_pointer_top frp_chk u_chk (.*);
